@@ rtl/core/ppu_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_pkg
// shared widths, codes and payload types of the particle pool update block
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int unsigned POOL_SIZE_DEF = 1024;

    localparam int SLOT_W    = 10;
    localparam int VAL_W     = 16;
    localparam int COUNT_W   = 11;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int SPIN_SHIFT = 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SPAWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DECAY = 2'd1;

    localparam logic [VAL_W-1:0] DRAG_RESET  = 16'hFFFF;
    localparam logic [VAL_W-1:0] DECAY_RESET = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] start_x;
        logic signed [VAL_W-1:0] start_y;
        logic [VAL_W-1:0]        start_angle;
        logic [VAL_W-1:0]        start_scale;
        logic signed [VAL_W-1:0] vel_x;
        logic signed [VAL_W-1:0] vel_y;
        logic signed [VAL_W-1:0] spin_rate;
        logic [VAL_W-1:0]        life_time;
        logic [VAL_W-1:0]        time_step;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic [VAL_W-1:0]        angle;
        logic [VAL_W-1:0]        scale;
        logic                    is_alive;
        logic [COUNT_W-1:0]      alive_count;
        logic [SLOT_W-1:0]       last_alive_index;
    } t_result;

    // one pool entry as held in the store
    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] angle;
        logic [VAL_W-1:0] scale;
        logic [VAL_W-1:0] vx;
        logic [VAL_W-1:0] vy;
        logic [VAL_W-1:0] spin;
        logic [VAL_W-1:0] life;
        logic             alive;
    } t_slot;

endpackage

@@ rtl/core/ppu_if.sv @@
// ----------------------------------------------------------------------------
// ppu interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface ppu_item_if;
    import ppu_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppu_result_if;
    import ppu_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppu_cfg_if;
    import ppu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [VAL_W-1:0]     wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

@@ rtl/core/ppu_advance.sv @@
// ----------------------------------------------------------------------------
// ppu_advance
// one-stage slot update: motion, spin, drag, lifetime and size decay
// ----------------------------------------------------------------------------
module ppu_advance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [ppu_pkg::SLOT_W-1:0]   i_idx,
    input  ppu_pkg::t_slot               i_slot,
    input  logic [ppu_pkg::VAL_W-1:0]    i_dt,
    input  logic [ppu_pkg::VAL_W-1:0]    i_drag,
    input  logic [ppu_pkg::VAL_W-1:0]    i_decay,
    output logic                         o_valid,
    output logic [ppu_pkg::SLOT_W-1:0]   o_idx,
    output ppu_pkg::t_slot               o_slot
);
    import ppu_pkg::*;

    logic signed [2*VAL_W:0] p_spin;
    logic signed [2*VAL_W:0] p_vx;
    logic signed [2*VAL_W:0] p_vy;
    logic [2*VAL_W-1:0]      p_scale;
    logic [VAL_W-1:0]        n_life;

    logic              r_valid;
    logic [SLOT_W-1:0] r_idx;
    logic [VAL_W-1:0]  r_x;
    logic [VAL_W-1:0]  r_y;
    logic [VAL_W-1:0]  r_angle;
    logic [VAL_W-1:0]  r_spin_d;
    logic [VAL_W-1:0]  r_spin;
    logic [VAL_W-1:0]  r_vx;
    logic [VAL_W-1:0]  r_vy;
    logic [VAL_W-1:0]  r_scale;
    logic [VAL_W-1:0]  r_life;

    // signed by unsigned products, floor by taking the upper bits
    assign p_spin  = $signed(i_slot.spin) * $signed({1'b0, i_dt});
    assign p_vx    = $signed(i_slot.vx) * $signed({1'b0, i_drag});
    assign p_vy    = $signed(i_slot.vy) * $signed({1'b0, i_drag});
    assign p_scale = i_slot.scale * i_decay;
    assign n_life  = (i_slot.life > i_dt) ? i_slot.life - i_dt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_idx    <= i_idx;
        r_x      <= i_slot.x + i_slot.vx;
        r_y      <= i_slot.y + i_slot.vy;
        r_angle  <= i_slot.angle;
        r_spin_d <= p_spin[VAL_W+SPIN_SHIFT-1:SPIN_SHIFT];
        r_spin   <= i_slot.spin;
        r_vx     <= p_vx[2*VAL_W-1:VAL_W];
        r_vy     <= p_vy[2*VAL_W-1:VAL_W];
        r_scale  <= p_scale[2*VAL_W-1:VAL_W];
        r_life   <= n_life;
    end

    always_comb begin
        o_valid        = r_valid;
        o_idx          = r_idx;
        o_slot.x       = r_x;
        o_slot.y       = r_y;
        o_slot.angle   = r_angle + r_spin_d;
        o_slot.vx      = r_vx;
        o_slot.vy      = r_vy;
        o_slot.spin    = r_spin;
        o_slot.life    = r_life;
        o_slot.alive   = (r_life != '0);
        o_slot.scale   = (r_life != '0) ? r_scale : '0;
    end

endmodule

@@ rtl/core/particle_pool_update.sv @@
// ----------------------------------------------------------------------------
// particle_pool_update
// fixed pool of fixed-point particles with spawn, tick and read transactions
// ----------------------------------------------------------------------------
// The pool lives in one synchronous memory of POOL_SIZE entries, one read and
// one write port, read data registered. After reset the block sweeps the
// memory to zero, one entry per cycle, over all POOL_SIZE entries; item ready
// stays low meanwhile, register writes are taken throughout. A spawn writes
// its slot in the cycle it is accepted and leaves item ready high. A read
// goes through the memory read, the result build and the output register,
// and the next item can be taken once the result is loaded there. A tick
// walks slots 0 to the larger of the last live slot and the spawn mark,
// capped to the pool, one slot per cycle through the memory read port and
// the update stage, followed by pipeline drain and result hand-off. One item
// is in work at a time; a finished result sits in the output register while
// the next transaction is accepted, and a second finished result waits, with
// item ready low, until the receiver takes the first.
// ----------------------------------------------------------------------------
module particle_pool_update #(
    parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppu_item_if.sink           i_item,
    ppu_result_if.source       o_result,
    ppu_cfg_if.sink            i_cfg
);
    import ppu_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TICK,
        S_READ,
        S_PUSH
    } t_state;

    // slot number to memory address
    function automatic logic [AW-1:0] to_addr(input logic [SLOT_W-1:0] s);
        logic [AW+SLOT_W-1:0] w;
        w = {{AW{1'b0}}, s};
        return w[AW-1:0];
    endfunction

    // pool memory
    t_slot r_mem [POOL_SIZE];
    t_slot r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_slot         mem_wdata;
    logic [AW-1:0] mem_raddr;

    // control
    t_state            r_state;
    logic [AW-1:0]     r_clr;
    logic [VAL_W-1:0]  r_drag;
    logic [VAL_W-1:0]  r_decay;
    logic [SLOT_W-1:0] r_last_live;
    logic [SLOT_W-1:0] r_walk_mark;
    logic [SLOT_W-1:0] r_bound;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_issuing;
    logic              r_v1;
    logic [SLOT_W-1:0] r_i1;
    logic [VAL_W-1:0]  r_dt;
    logic [COUNT_W-1:0] r_count;
    logic [SLOT_W-1:0] r_last;
    logic              r_rd_ok;
    t_result           r_res;
    logic              r_out_valid;
    t_result           r_out;

    // update stage output
    logic              adv_valid;
    logic [SLOT_W-1:0] adv_idx;
    t_slot             adv_slot;

    logic              item_acc;
    logic              slot_ok;
    logic [SLOT_W-1:0] n_bound;
    t_result           tick_res;
    t_result           read_res;

    assign i_item.ready  = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign item_acc = i_item.valid && i_item.ready;
    assign slot_ok  = (32'(i_item.data.slot) < POOL_SIZE);

    // walk bound, capped to the pool
    always_comb begin
        n_bound = (r_last_live > r_walk_mark) ? r_last_live : r_walk_mark;
        if (32'(n_bound) > POOL_SIZE - 1) begin
            n_bound = SLOT_W'(POOL_SIZE - 1);
        end
    end

    // result words for a finished tick and for a slot readout
    always_comb begin
        tick_res                  = '0;
        tick_res.alive_count      = r_count;
        tick_res.last_alive_index = r_last;
        read_res                  = '0;
        if (r_rd_ok) begin
            read_res.pos_x    = r_rd_data.x;
            read_res.pos_y    = r_rd_data.y;
            read_res.angle    = r_rd_data.angle;
            read_res.scale    = r_rd_data.scale;
            read_res.is_alive = r_rd_data.alive;
        end
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        priority if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (adv_valid) begin
            mem_we    = 1'b1;
            mem_waddr = to_addr(adv_idx);
            mem_wdata = adv_slot;
        end else if (item_acc && i_item.data.kind == KIND_SPAWN && slot_ok) begin
            mem_we          = 1'b1;
            mem_waddr       = to_addr(i_item.data.slot);
            mem_wdata.x     = i_item.data.start_x;
            mem_wdata.y     = i_item.data.start_y;
            mem_wdata.angle = i_item.data.start_angle;
            mem_wdata.scale = i_item.data.start_scale;
            mem_wdata.vx    = i_item.data.vel_x;
            mem_wdata.vy    = i_item.data.vel_y;
            mem_wdata.spin  = i_item.data.spin_rate;
            mem_wdata.life  = i_item.data.life_time;
            mem_wdata.alive = 1'b1;
        end else begin
            mem_we = 1'b0;
        end
        // the walk reads by its own index, otherwise the incoming slot
        mem_raddr = (r_state == S_TICK) ? to_addr(r_rd_idx) : to_addr(i_item.data.slot);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // slot update stage
    ppu_advance u_advance (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_idx   (r_i1),
        .i_slot  (r_rd_data),
        .i_dt    (r_dt),
        .i_drag  (r_drag),
        .i_decay (r_decay),
        .o_valid (adv_valid),
        .o_idx   (adv_idx),
        .o_slot  (adv_slot)
    );

    // sequencer, registers and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_drag      <= DRAG_RESET;
            r_decay     <= DECAY_RESET;
            r_last_live <= '0;
            r_walk_mark <= '0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.addr == REG_DRAG_FACTOR) begin
                    r_drag <= i_cfg.wdata;
                end else if (i_cfg.addr == REG_SCALE_DECAY) begin
                    r_decay <= i_cfg.wdata;
                end
            end

            // a slot read goes out on every issuing cycle of the walk
            r_v1 <= (r_state == S_TICK) && r_issuing;

            // output register: load a finished result, release on hand-off
            if (r_state == S_PUSH && (!r_out_valid || o_result.ready)) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (item_acc) begin
                        if (i_item.data.kind == KIND_SPAWN) begin
                            if (slot_ok && i_item.data.slot > r_walk_mark) begin
                                r_walk_mark <= i_item.data.slot;
                            end
                        end else if (i_item.data.kind == KIND_TICK) begin
                            r_bound   <= n_bound;
                            r_rd_idx  <= '0;
                            r_issuing <= 1'b1;
                            r_dt      <= i_item.data.time_step;
                            r_count   <= '0;
                            r_last    <= '0;
                            r_state   <= S_TICK;
                        end else if (i_item.data.kind == KIND_READ) begin
                            r_rd_ok <= slot_ok;
                            r_state <= S_READ;
                        end
                    end
                end
                S_TICK: begin
                    // issue one slot read per cycle
                    if (r_issuing) begin
                        r_i1 <= r_rd_idx;
                        if (r_rd_idx == r_bound) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    // tally the written-back slots
                    if (adv_valid && adv_slot.alive) begin
                        r_count <= r_count + 1'b1;
                        r_last  <= adv_idx;
                    end
                    // walk drained
                    if (!r_issuing && !r_v1 && !adv_valid) begin
                        r_res       <= tick_res;
                        r_last_live <= r_last;
                        r_walk_mark <= '0;
                        r_state     <= S_PUSH;
                    end
                end
                S_READ: begin
                    r_res   <= read_res;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // hand over once the output register is free
                    if (!r_out_valid || o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the particle pool update block
// ----------------------------------------------------------------------------
// Drives spawn, tick and read transactions into the block and keeps its own
// copy of the particle pool and of the drag and decay registers. Every
// accepted item is applied to that copy, and any tick summary or slot readout
// it produces is queued. Each result the block hands over is compared field
// by field with the oldest queued one. Directed items cover the field
// extremes and the corner cases of the update. Random traffic then runs under
// several register settings, with random idling on both channels, a long
// result stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppu_pkg::*;

    localparam int unsigned POOL = POOL_SIZE_DEF;
    localparam int CLK_PERIOD = 20;
    // spawns give no result, so allow the last one to finish before a write
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_PRINTED = 40;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    ppu_item_if   item_ch ();
    ppu_result_if result_ch ();
    ppu_cfg_if    cfg_ch ();

    particle_pool_update i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // shadow pool and registers
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] pool_x     [POOL];
    logic [VAL_W-1:0] pool_y     [POOL];
    logic [VAL_W-1:0] pool_angle [POOL];
    logic [VAL_W-1:0] pool_scale [POOL];
    logic [VAL_W-1:0] pool_vx    [POOL];
    logic [VAL_W-1:0] pool_vy    [POOL];
    logic [VAL_W-1:0] pool_spin  [POOL];
    logic [VAL_W-1:0] pool_life  [POOL];
    logic             pool_alive [POOL];
    int unsigned      live_top;     // highest slot alive after the last tick
    int unsigned      spawn_mark;   // highest slot spawned since the last tick
    logic [VAL_W-1:0] drag_q;
    logic [VAL_W-1:0] decay_q;

    // readouts and tick summaries still owed by the block
    t_result pending_readouts [$];

    int unsigned mismatch_count;
    int unsigned n_spawns, n_ticks, n_reads, n_ignored, n_checked, n_reg_writes;
    bit          idling_on;
    int unsigned ready_hold_cycles;

    // ------------------------------------------------------------------------
    // clock and time limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // worst correct run is well under 15 ms, even with every item a full walk
    initial begin
        #(60ms);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction: apply one accepted item to the shadow pool
    // ------------------------------------------------------------------------
    task automatic apply_to_pool(input t_item it);
        t_result            r;
        int unsigned        s, bound, count, last;
        logic signed [32:0] sprod;
        logic [31:0]        uprod;
        logic [VAL_W-1:0]   life;
        r = '0;
        case (it.kind)
            KIND_SPAWN: begin
                pool_x[it.slot]     = it.start_x;
                pool_y[it.slot]     = it.start_y;
                pool_angle[it.slot] = it.start_angle;
                pool_scale[it.slot] = it.start_scale;
                pool_vx[it.slot]    = it.vel_x;
                pool_vy[it.slot]    = it.vel_y;
                pool_spin[it.slot]  = it.spin_rate;
                pool_life[it.slot]  = it.life_time;
                // marked alive even with zero life, until the next tick
                pool_alive[it.slot] = 1'b1;
                if (32'(it.slot) > spawn_mark) spawn_mark = 32'(it.slot);
                n_spawns++;
            end
            KIND_TICK: begin
                bound = (live_top > spawn_mark) ? live_top : spawn_mark;
                if (bound > POOL - 1) bound = POOL - 1;
                count = 0;
                last  = 0;
                for (s = 0; s <= bound; s++) begin
                    // positions wrap round the edge of [-1,1) by plain overflow
                    pool_x[s] = pool_x[s] + pool_vx[s];
                    pool_y[s] = pool_y[s] + pool_vy[s];
                    // floor of spin * step / 256, low 16 bits
                    sprod = $signed(pool_spin[s]) * $signed({1'b0, it.time_step});
                    pool_angle[s] = pool_angle[s] + sprod[23:8];
                    // drag floors towards minus infinity, so -1 stays -1
                    sprod = $signed(pool_vx[s]) * $signed({1'b0, drag_q});
                    pool_vx[s] = sprod[31:16];
                    sprod = $signed(pool_vy[s]) * $signed({1'b0, drag_q});
                    pool_vy[s] = sprod[31:16];
                    life = (pool_life[s] > it.time_step) ?
                           pool_life[s] - it.time_step : '0;
                    pool_life[s]  = life;
                    pool_alive[s] = (life != '0);
                    uprod = pool_scale[s] * decay_q;
                    pool_scale[s] = pool_alive[s] ? uprod[31:16] : '0;
                    if (pool_alive[s]) begin
                        count++;
                        last = s;
                    end
                end
                live_top   = last;
                spawn_mark = 0;
                r.alive_count      = COUNT_W'(count);
                r.last_alive_index = SLOT_W'(last);
                pending_readouts.push_back(r);
                n_ticks++;
            end
            KIND_READ: begin
                r.pos_x    = pool_x[it.slot];
                r.pos_y    = pool_y[it.slot];
                r.angle    = pool_angle[it.slot];
                r.scale    = pool_scale[it.slot];
                r.is_alive = pool_alive[it.slot];
                pending_readouts.push_back(r);
                n_reads++;
            end
            default: begin
                // unused kind: accepted and dropped
                n_ignored++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // result checker: one compare per accepted result transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (pending_readouts.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing pending: %h",
                                          n_checked, got));
            end else begin
                want = pending_readouts.pop_front();
                if (got.pos_x !== want.pos_x)
                    report_mismatch($sformatf("result %0d pos_x %h, want %h",
                                              n_checked, got.pos_x, want.pos_x));
                if (got.pos_y !== want.pos_y)
                    report_mismatch($sformatf("result %0d pos_y %h, want %h",
                                              n_checked, got.pos_y, want.pos_y));
                if (got.angle !== want.angle)
                    report_mismatch($sformatf("result %0d angle %h, want %h",
                                              n_checked, got.angle, want.angle));
                if (got.scale !== want.scale)
                    report_mismatch($sformatf("result %0d scale %h, want %h",
                                              n_checked, got.scale, want.scale));
                if (got.is_alive !== want.is_alive)
                    report_mismatch($sformatf("result %0d is_alive %b, want %b",
                                              n_checked, got.is_alive, want.is_alive));
                if (got.alive_count !== want.alive_count)
                    report_mismatch($sformatf("result %0d alive_count %0d, want %0d",
                                              n_checked, got.alive_count,
                                              want.alive_count));
                if (got.last_alive_index !== want.last_alive_index)
                    report_mismatch($sformatf("result %0d last_alive_index %0d, want %0d",
                                              n_checked, got.last_alive_index,
                                              want.last_alive_index));
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_cycles != 0) begin
                // long hold-off, long enough for the block to back up its input
                result_ch.ready <= 1'b0;
                repeat (ready_hold_cycles) @(posedge i_clk);
                ready_hold_cycles = 0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // item sender and register writer
    // ------------------------------------------------------------------------
    task automatic send_item(input t_item it);
        // optional gap before the item, with valid low for the gap
        if (idling_on && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        apply_to_pool(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.wdata <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_DRAG_FACTOR: drag_q  = value;
            REG_SCALE_DECAY: decay_q = value;
            default: ;
        endcase
        n_reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering items and wait until every owed result has been handed over
    task automatic wait_for_readouts(input int settle);
        item_ch.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic t_item roll_item(input bit want_result);
        t_item       it;
        int unsigned pick;
        pick = want_result ? $urandom_range(40, 95) : $urandom_range(0, 99);
        it.kind = (pick < 40) ? KIND_SPAWN :
                  (pick < 60) ? KIND_TICK  :
                  (pick < 97) ? KIND_READ  : KIND_UNUSED;
        // mostly a small working set, now and then anywhere in the pool
        it.slot = ($urandom_range(0, 11) == 0) ? SLOT_W'($urandom_range(0, POOL - 1))
                                               : SLOT_W'($urandom_range(0, 31));
        it.start_x     = VAL_W'($urandom);
        it.start_y     = VAL_W'($urandom);
        it.start_angle = VAL_W'($urandom);
        it.start_scale = VAL_W'($urandom);
        it.vel_x       = $urandom_range(0, 1) ? VAL_W'($urandom)
                                              : VAL_W'($urandom_range(0, 255) - 128);
        it.vel_y       = $urandom_range(0, 1) ? VAL_W'($urandom)
                                              : VAL_W'($urandom_range(0, 255) - 128);
        it.spin_rate   = VAL_W'($urandom);
        case ($urandom_range(0, 9))
            0:       it.life_time = '0;
            1, 2:    it.life_time = VAL_W'($urandom);
            default: it.life_time = VAL_W'($urandom_range(1, 400));
        endcase
        case ($urandom_range(0, 9))
            0:          it.time_step = VAL_W'($urandom);
            1, 2, 3:    it.time_step = VAL_W'($urandom_range(0, 1000));
            default:    it.time_step = VAL_W'($urandom_range(0, 64));
        endcase
        return it;
    endfunction

    function automatic t_item make_spawn(input int unsigned slot,
                                         input int x, input int y,
                                         input int unsigned ang, input int unsigned scl,
                                         input int vx, input int vy, input int spin,
                                         input int unsigned life);
        t_item it;
        it = roll_item(1'b0);
        it.kind        = KIND_SPAWN;
        it.slot        = SLOT_W'(slot);
        it.start_x     = VAL_W'(x);
        it.start_y     = VAL_W'(y);
        it.start_angle = VAL_W'(ang);
        it.start_scale = VAL_W'(scl);
        it.vel_x       = VAL_W'(vx);
        it.vel_y       = VAL_W'(vy);
        it.spin_rate   = VAL_W'(spin);
        it.life_time   = VAL_W'(life);
        return it;
    endfunction

    function automatic t_item make_tick(input int unsigned step);
        t_item it;
        it = roll_item(1'b0);
        it.kind      = KIND_TICK;
        it.time_step = VAL_W'(step);
        return it;
    endfunction

    function automatic t_item make_read(input int unsigned slot);
        t_item it;
        it = roll_item(1'b0);
        it.kind = KIND_READ;
        it.slot = SLOT_W'(slot);
        return it;
    endfunction

    // random items, counting only those the block acts on
    task automatic run_traffic(input int unsigned n_items);
        t_item       it;
        int unsigned done;
        done = 0;
        while (done < n_items) begin
            it = roll_item(1'b0);
            send_item(it);
            if (it.kind != KIND_UNUSED) done++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // spawns at both ends of the pool with extreme fields, then read back,
    // including a slot that was never spawned
    task automatic test_spawn_and_read();
        send_item(make_spawn(0, 32767, -32768, 65535, 65535, 1, -1, 32767, 65535));
        send_item(make_spawn(POOL - 1, -32768, 32767, 0, 0, -32768, 32767, -32768, 1));
        // zero lifetime: alive until the first tick
        send_item(make_spawn(5, 0, 0, 100, 40000, -1, -1, -1, 0));
        send_item(make_read(0));
        send_item(make_read(POOL - 1));
        send_item(make_read(5));
        send_item(make_read(700));
    endtask

    // position wrap, angle update, velocity stuck at -1, lifetime expiry with
    // saturation, respawn over a live slot and a tick over an empty pool
    task automatic test_tick_lifetimes();
        send_item(make_tick(1));
        send_item(make_read(0));
        send_item(make_read(POOL - 1));
        send_item(make_read(5));
        send_item(make_spawn(0, -5, 7, 1234, 30000, 300, -300, -200, 3));
        send_item(make_tick(0));
        send_item(make_read(0));
        send_item(make_tick(65535));
        send_item(make_read(0));
        send_item(make_tick(100));
        send_item(make_read(POOL - 1));
    endtask

    // unused kind must be swallowed without a result
    task automatic test_unused_kind();
        t_item it;
        it = make_read(3);
        it.kind = KIND_UNUSED;
        send_item(it);
        send_item(make_read(3));
    endtask

    // random traffic under a range of drag and decay settings, extremes included
    task automatic test_register_sweep();
        logic [VAL_W-1:0] drags  [6];
        logic [VAL_W-1:0] decays [6];
        int               k;
        drags  = '{16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000};
        decays = '{16'hFFFF, 16'h0000, 16'hC000, 16'h0000, 16'hFFFF, 16'h0000};
        drags[5]  = VAL_W'($urandom);
        decays[5] = VAL_W'($urandom);
        for (k = 0; k < 6; k++) begin
            wait_for_readouts(SETTLE_CYCLES);
            write_reg(REG_DRAG_FACTOR, drags[k]);
            write_reg(REG_SCALE_DECAY, decays[k]);
            // one phase with no idling at all, the rest with random gaps
            idling_on = (k != 2);
            run_traffic(75);
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        int n;
        wait_for_readouts(SETTLE_CYCLES);
        ready_hold_cycles = 400;
        for (n = 0; n < 24; n++) send_item(roll_item(1'b1));
        // sender pauses here until the backlog has drained
        wait_for_readouts(SETTLE_CYCLES);
        for (n = 0; n < 20; n++) send_item(roll_item(1'b0));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned s;
        // inputs known from the first step
        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.addr   <= REG_DRAG_FACTOR;
        cfg_ch.wdata  <= '0;
        mismatch_count    = 0;
        n_spawns          = 0;
        n_ticks           = 0;
        n_reads           = 0;
        n_ignored         = 0;
        n_checked         = 0;
        n_reg_writes      = 0;
        ready_hold_cycles = 0;
        idling_on         = 1'b1;
        // shadow state as after reset
        for (s = 0; s < POOL; s++) begin
            pool_x[s]     = '0;
            pool_y[s]     = '0;
            pool_angle[s] = '0;
            pool_scale[s] = '0;
            pool_vx[s]    = '0;
            pool_vy[s]    = '0;
            pool_spin[s]  = '0;
            pool_life[s]  = '0;
            pool_alive[s] = 1'b0;
        end
        live_top   = 0;
        spawn_mark = 0;
        drag_q     = DRAG_RESET;
        decay_q    = DECAY_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs with the registers at their reset values
        test_spawn_and_read();
        test_tick_lifetimes();
        test_unused_kind();
        test_register_sweep();
        test_output_backpressure();

        // closing stretch at full rate on both sides
        idling_on = 1'b0;
        run_traffic(60);

        wait_for_readouts(DRAIN_CYCLES);
        $display("covered %0d spawns, %0d ticks, %0d reads, %0d unused-kind items",
                 n_spawns, n_ticks, n_reads, n_ignored);
        $display("checked %0d results over %0d register writes, %0d mismatches",
                 n_checked, n_reg_writes, mismatch_count);
        if (mismatch_count == 0 && pending_readouts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ppu_pkg.sv
rtl/core/ppu_if.sv
rtl/core/ppu_advance.sv
rtl/core/particle_pool_update.sv
sim/tb_top.sv
